// ===== rtl/mru_pkg.sv =====
// shared constants, codes and control types for the mru list
// no dependencies
package mru_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int KEY_BITS   = 32;
	localparam int NCELL      = LIST_DEPTH + 1;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int CFG_W      = 5;
	localparam int MODE_W     = 3;
	localparam int STAT_W     = 2;

	localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(16);

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FIND       = 3'd2;
	localparam logic [MODE_W-1:0] MODE_GET        = 3'd3;
	localparam logic [MODE_W-1:0] MODE_MOVE_FRONT = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	localparam logic [1:0] OP_HOLD     = 2'd0;
	localparam logic [1:0] OP_SHIFT_IN = 2'd1;
	localparam logic [1:0] OP_COMPACT  = 2'd2;
	localparam logic [1:0] OP_WRITE    = 2'd3;

	typedef struct packed {
		logic [1:0]          op;
		logic [CNT_W-1:0]    sel_pos;
		logic [CNT_W-1:0]    used;
		logic [KEY_BITS-1:0] key;
	} cell_ctrl_t;

	typedef struct packed {
		logic [STAT_W-1:0]   status;
		logic [IDX_W-1:0]    found_index;
		logic [KEY_BITS-1:0] read_key;
		logic [CNT_W-1:0]    entry_count;
	} result_t;

endpackage

// ===== rtl/mru_cell.sv =====
// one list position: key register, removal flag, compare and chain links
// depends on mru_pkg
module mru_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mru_pkg::cell_ctrl_t          ctrl,
	input  logic [mru_pkg::CNT_W-1:0]    pos,
	input  logic [mru_pkg::KEY_BITS-1:0] left_key,
	input  logic                         left_dead,
	input  logic [mru_pkg::KEY_BITS-1:0] right_key,
	input  logic                         right_dead,
	input  logic                         shift_in,
	input  logic                         seen_in,
	output logic [mru_pkg::KEY_BITS-1:0] key_q,
	output logic                         dead_q,
	output logic                         match,
	output logic                         shift_out,
	output logic                         seen_out,
	output logic                         first
);
	import mru_pkg::*;

	assign match     = (key_q == ctrl.key) && (pos < ctrl.used);
	assign shift_out = shift_in | dead_q;
	assign seen_out  = seen_in | match;
	assign first     = match & ~seen_in;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_SHIFT_IN: if (pos <= ctrl.sel_pos) key_q <= left_key;
			OP_COMPACT:  if (shift_out) key_q <= right_key;
			OP_WRITE:    if (pos == ctrl.sel_pos) key_q <= ctrl.key;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_SHIFT_IN: if (pos <= ctrl.sel_pos) dead_q <= left_dead;
				OP_COMPACT:  if (shift_out) dead_q <= right_dead;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/mru_list_with_dedup.sv =====
// mru list: accepts one item per cycle while idle and the output is not stalled; results are registered
// push-front runs in the cell chain in steps and holds off new items until it finishes
// (shift the key in, one compaction step per removed duplicate, then one final check)
// a waiting result is held in a pending register while the output is stalled
// reset clears the entry count register used_q, output valid and state; limit_q resets to 16; keys undefined
// depends on mru_pkg and mru_cell
module mru_list_with_dedup (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mru_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mru_pkg::MODE_W-1:0]   mode,
	input  logic [mru_pkg::KEY_BITS-1:0] key,
	input  logic [mru_pkg::IDX_W-1:0]    item_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mru_pkg::STAT_W-1:0]   status,
	output logic [mru_pkg::IDX_W-1:0]    found_index,
	output logic [mru_pkg::KEY_BITS-1:0] read_key,
	output logic [mru_pkg::CNT_W-1:0]    entry_count
);
	import mru_pkg::*;

	localparam int LW = (CFG_W > CNT_W + 1) ? CFG_W : CNT_W + 1;

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_COMPACT = 2'd1;
	localparam logic [1:0] S_WAIT    = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [CNT_W-1:0] used_q, used_d;
	logic [CFG_W-1:0] limit_q;
	logic             out_valid_q;
	result_t          out_q, res_q, fin_res;
	logic             fin;
	cell_ctrl_t       ctrl;

	logic [KEY_BITS-1:0] cell_key [NCELL];
	logic                cell_dead [NCELL];
	logic                cell_match [NCELL];
	logic                cell_first [NCELL];
	logic [KEY_BITS-1:0] lkey [NCELL];
	logic                ldead [NCELL];
	logic [KEY_BITS-1:0] rkey [NCELL];
	logic                rdead [NCELL];
	logic                shift_c [NCELL+1];
	logic                seen_c [NCELL+1];

	assign shift_c[0] = 1'b0;
	assign seen_c[0]  = 1'b0;

	genvar g;
	generate
		for (g = 0; g < NCELL; g++) begin : g_cell
			if (g == 0) begin : g_head
				assign lkey[g]  = ctrl.key;
				assign ldead[g] = 1'b0;
			end else begin : g_body
				assign lkey[g]  = cell_key[g-1];
				assign ldead[g] = cell_match[g-1];
			end
			if (g == NCELL - 1) begin : g_tail
				assign rkey[g]  = cell_key[g];
				assign rdead[g] = 1'b0;
			end else begin : g_mid
				assign rkey[g]  = cell_key[g+1];
				assign rdead[g] = cell_dead[g+1];
			end
			mru_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.pos        (CNT_W'(g)),
				.left_key   (lkey[g]),
				.left_dead  (ldead[g]),
				.right_key  (rkey[g]),
				.right_dead (rdead[g]),
				.shift_in   (shift_c[g]),
				.seen_in    (seen_c[g]),
				.key_q      (cell_key[g]),
				.dead_q     (cell_dead[g]),
				.match      (cell_match[g]),
				.shift_out  (shift_c[g+1]),
				.seen_out   (seen_c[g+1]),
				.first      (cell_first[g])
			);
		end
	endgenerate

	logic [IDX_W-1:0]    found;
	logic [KEY_BITS-1:0] sel_key;
	logic                in_range;
	logic                slot_free;
	logic [LW-1:0]       lim;
	logic [LW-1:0]       run_cnt;
	logic [CNT_W-1:0]    trunc_cnt;

	always_comb begin
		found = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			if (cell_first[i]) found = found | IDX_W'(i);
		end
	end

	assign sel_key   = cell_key[{1'b0, item_index}];
	assign in_range  = {1'b0, item_index} < used_q;
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		if (limit_q == '0) lim = LW'(1);
		else if (LW'(limit_q) > LW'(LIST_DEPTH)) lim = LW'(LIST_DEPTH);
		else lim = LW'(limit_q);
		run_cnt = LW'(used_q) + LW'(1);
		if (run_cnt > lim) trunc_cnt = lim[CNT_W-1:0];
		else trunc_cnt = run_cnt[CNT_W-1:0];
	end

	always_comb begin
		ctrl.op      = OP_HOLD;
		ctrl.sel_pos = '0;
		ctrl.used    = used_q;
		ctrl.key     = key;
		state_d      = state_q;
		used_d       = used_q;
		fin          = 1'b0;
		fin_res      = '0;
		fin_res.status = STAT_MISS;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (mode)
						MODE_PUSH_FRONT: begin
							ctrl.op      = OP_SHIFT_IN;
							ctrl.sel_pos = CNT_W'(LIST_DEPTH);
							state_d      = S_COMPACT;
						end
						MODE_PUSH_BACK: begin
							fin = 1'b1;
							if (used_q >= CNT_W'(LIST_DEPTH)) begin
								fin_res.status = STAT_FULL;
							end else begin
								ctrl.op        = OP_WRITE;
								ctrl.sel_pos   = used_q;
								used_d         = used_q + CNT_W'(1);
								fin_res.status = STAT_OK;
							end
						end
						MODE_FIND: begin
							fin = 1'b1;
							if (seen_c[NCELL]) begin
								fin_res.status      = STAT_OK;
								fin_res.found_index = found;
							end
						end
						MODE_GET: begin
							fin = 1'b1;
							if (in_range) begin
								fin_res.status   = STAT_OK;
								fin_res.read_key = sel_key;
							end
						end
						MODE_MOVE_FRONT: begin
							fin = 1'b1;
							if (in_range) begin
								ctrl.op        = OP_SHIFT_IN;
								ctrl.sel_pos   = CNT_W'(item_index);
								ctrl.key       = sel_key;
								fin_res.status = STAT_OK;
							end
						end
						MODE_CLEAR: begin
							fin            = 1'b1;
							used_d         = '0;
							fin_res.status = STAT_OK;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_COMPACT: begin
				ctrl.op = OP_COMPACT;
				if (shift_c[NCELL]) begin
					used_d = used_q - CNT_W'(1);
				end else begin
					fin            = 1'b1;
					used_d         = trunc_cnt;
					fin_res.status = STAT_OK;
				end
			end
			S_WAIT: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		fin_res.entry_count = used_d;
		if (fin) state_d = slot_free ? S_IDLE : S_WAIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			if (cfg_we) limit_q <= cfg_wdata;
			if (fin && slot_free) out_valid_q <= 1'b1;
			else if (state_q == S_WAIT && slot_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			if (slot_free) out_q <= fin_res;
			else res_q <= fin_res;
		end else if (state_q == S_WAIT && slot_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign found_index = out_q.found_index;
	assign read_key    = out_q.read_key;
	assign entry_count = out_q.entry_count;

endmodule
